### rtl/pwfp_pkg.sv
// Shared types and constants for the protobuf wire-format field parser.
// No dependencies; every other rtl file refers to it by scoped names.
package pwfp_pkg;

    localparam logic [63:0] MAX_MESSAGE_BYTES_DEF = 64'd65536;

    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
    localparam int VARINT_MAX_BYTES = 10;
    localparam int VCNT_W           = 4;
    localparam int FIXED32_BYTES    = 4;
    localparam int FIXED64_BYTES    = 8;
    localparam int S_TDATA_W        = 8;
    localparam int M_TDATA_W        = 120;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    typedef enum logic [5:0] {
        PH_KEY     = 6'b000001,
        PH_VALUE   = 6'b000010,
        PH_LENGTH  = 6'b000100,
        PH_PAYLOAD = 6'b001000,
        PH_SKIP    = 6'b010000,
        PH_DRAIN   = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_VARINT  = 3'd0,
        KIND_LEN_HDR = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_FIXED   = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_LONG      = 3'd1,
        ERR_FIELD0    = 3'd2,
        ERR_WIRE      = 3'd3,
        ERR_LEN       = 3'd4,
        ERR_TRUNCATED = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } item_t;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_AW:0]   count;
    } qstat_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] field_number;
        logic [2:0]  wire_type;
        logic [63:0] value;
        logic [15:0] position;
        logic        end_of_message;
        err_t        error_code;
    } result_t;

endpackage

### rtl/pwfp_front.sv
// Input stage: takes stream transfers, drops bare non-closing markers,
// holds one item for the queue. Depends on pwfp_pkg.
module pwfp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic [0:0]          s_tuser,
    input  logic                s_tlast,
    input  pwfp_pkg::qstat_t    qstat,
    output logic                push,
    output pwfp_pkg::item_t     push_item
);

    logic            hold_valid_reg;
    logic            hold_valid_next;
    pwfp_pkg::item_t hold_item_reg;
    logic            accept;

    assign push      = hold_valid_reg && !qstat.full;
    assign s_tready  = !hold_valid_reg || !qstat.full;
    assign accept    = s_tvalid && s_tready;
    assign push_item = hold_item_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg && !push;
        if (accept) begin
            // a bare marker without last changes nothing downstream
            hold_valid_next = s_tuser[0] || s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_item_reg.data_byte  <= s_tdata;
            hold_item_reg.byte_valid <= s_tuser[0];
            hold_item_reg.last       <= s_tlast;
        end
    end

endmodule

### rtl/pwfp_queue.sv
// Short flop queue between the input stage and the parser.
// Depends on pwfp_pkg for depth and item type.
module pwfp_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pwfp_pkg::item_t     push_item,
    input  logic                pop,
    output pwfp_pkg::item_t     head,
    output pwfp_pkg::qstat_t    qstat
);

    pwfp_pkg::item_t                 slot_reg [pwfp_pkg::QUEUE_DEPTH];
    logic [pwfp_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pwfp_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pwfp_pkg::QUEUE_AW:0]     count_reg, count_next;
    logic                            do_push, do_pop;

    assign qstat.count = count_reg;
    assign qstat.full  = (count_reg == (pwfp_pkg::QUEUE_AW+1)'(pwfp_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = slot_reg[rd_ptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/pwfp_back.sv
// Parser: wire-format state machine, one queued item per cycle unless the
// result output register holds an untaken result. Depends on pwfp_pkg.
module pwfp_back #(
    parameter logic [63:0] MAX_MESSAGE_BYTES = pwfp_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pwfp_pkg::item_t     head,
    input  pwfp_pkg::qstat_t    qstat,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output pwfp_pkg::result_t   result
);

    localparam int REM_W = $clog2(MAX_MESSAGE_BYTES + 64'd1);

    pwfp_pkg::phase_t               phase_reg, phase_next;
    logic [63:0]                    acc_reg, acc_next;
    logic [pwfp_pkg::VCNT_W-1:0]    cnt_reg, cnt_next;
    logic [31:0]                    fn_reg, fn_next;
    logic [2:0]                     wt_reg, wt_next;
    logic [REM_W-1:0]               rem_reg, rem_next;
    logic [15:0]                    bpos_reg, bpos_next;
    pwfp_pkg::err_t                 err_reg, err_next;
    logic                           out_valid_reg, out_valid_next;
    pwfp_pkg::result_t              out_reg, res;
    logic                           produce;

    assign pop      = !qstat.empty && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

    always_comb begin
        logic [63:0]      fed_bits;
        logic [63:0]      acc_fed;
        logic             is_long;
        logic             done;
        logic [REM_W-1:0] rem_dec;
        logic             emit;
        logic [15:0]      pos_cur;

        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        fn_next    = fn_reg;
        wt_next    = wt_reg;
        rem_next   = rem_reg;
        bpos_next  = bpos_reg;
        err_next   = err_reg;
        emit       = 1'b0;
        pos_cur    = bpos_reg;

        fed_bits = '0;
        for (int i = 0; i < pwfp_pkg::VARINT_MAX_BYTES; i++) begin
            if (cnt_reg == pwfp_pkg::VCNT_W'(i)) begin
                fed_bits = 64'(head.data_byte[6:0]) << (7 * i);
            end
        end
        acc_fed = acc_reg | fed_bits;
        is_long = (cnt_reg >= pwfp_pkg::VCNT_W'(pwfp_pkg::VARINT_MAX_BYTES));
        done    = !head.data_byte[7];
        rem_dec = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;

        res                = '0;
        res.kind           = pwfp_pkg::KIND_END;
        res.error_code     = pwfp_pkg::ERR_NONE;

        if (head.byte_valid) begin
            bpos_next = bpos_reg + 16'd1;
            case (phase_reg)
                pwfp_pkg::PH_KEY, pwfp_pkg::PH_VALUE, pwfp_pkg::PH_LENGTH: begin
                    if (is_long) begin
                        err_next   = pwfp_pkg::ERR_LONG;
                        phase_next = pwfp_pkg::PH_DRAIN;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end else if (!done) begin
                        acc_next = acc_fed;
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        acc_next = '0;
                        cnt_next = '0;
                        case (phase_reg)
                            pwfp_pkg::PH_KEY: begin
                                fn_next = acc_fed[34:3];
                                wt_next = acc_fed[2:0];
                                if (acc_fed[34:3] == 32'd0) begin
                                    err_next   = pwfp_pkg::ERR_FIELD0;
                                    phase_next = pwfp_pkg::PH_DRAIN;
                                end else if (acc_fed[2:0] == pwfp_pkg::WT_VARINT) begin
                                    phase_next = pwfp_pkg::PH_VALUE;
                                end else if (acc_fed[2:0] == pwfp_pkg::WT_LEN) begin
                                    phase_next = pwfp_pkg::PH_LENGTH;
                                end else if (acc_fed[2:0] == pwfp_pkg::WT_I32) begin
                                    rem_next   = REM_W'(pwfp_pkg::FIXED32_BYTES);
                                    phase_next = pwfp_pkg::PH_SKIP;
                                end else if (acc_fed[2:0] == pwfp_pkg::WT_I64) begin
                                    rem_next   = REM_W'(pwfp_pkg::FIXED64_BYTES);
                                    phase_next = pwfp_pkg::PH_SKIP;
                                end else begin
                                    err_next   = pwfp_pkg::ERR_WIRE;
                                    phase_next = pwfp_pkg::PH_DRAIN;
                                end
                            end
                            pwfp_pkg::PH_VALUE: begin
                                emit         = 1'b1;
                                res.kind     = pwfp_pkg::KIND_VARINT;
                                res.value    = acc_fed;
                                res.position = pos_cur;
                                phase_next   = pwfp_pkg::PH_KEY;
                            end
                            default: begin
                                if (acc_fed > MAX_MESSAGE_BYTES) begin
                                    err_next   = pwfp_pkg::ERR_LEN;
                                    phase_next = pwfp_pkg::PH_DRAIN;
                                end else begin
                                    emit         = 1'b1;
                                    res.kind     = pwfp_pkg::KIND_LEN_HDR;
                                    res.value    = acc_fed;
                                    res.position = bpos_next;
                                    rem_next     = acc_fed[REM_W-1:0];
                                    phase_next   = (acc_fed != 64'd0) ? pwfp_pkg::PH_PAYLOAD
                                                                      : pwfp_pkg::PH_KEY;
                                end
                            end
                        endcase
                    end
                end
                pwfp_pkg::PH_PAYLOAD: begin
                    emit         = 1'b1;
                    res.kind     = pwfp_pkg::KIND_PAYLOAD;
                    res.value    = 64'(head.data_byte);
                    res.position = pos_cur;
                    rem_next     = rem_dec;
                    if (rem_dec == '0) begin
                        phase_next = pwfp_pkg::PH_KEY;
                    end
                end
                pwfp_pkg::PH_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        emit         = 1'b1;
                        res.kind     = pwfp_pkg::KIND_FIXED;
                        res.position = pos_cur;
                        phase_next   = pwfp_pkg::PH_KEY;
                    end
                end
                default: begin
                end
            endcase
        end

        if (head.last) begin
            if (err_next == pwfp_pkg::ERR_NONE &&
                !(phase_next == pwfp_pkg::PH_KEY && cnt_next == '0)) begin
                res.error_code = pwfp_pkg::ERR_TRUNCATED;
            end else begin
                res.error_code = err_next;
            end
            if (!emit) begin
                res.kind     = pwfp_pkg::KIND_END;
                res.value    = '0;
                res.position = bpos_next;
            end
            res.end_of_message = 1'b1;
            // message closed: back to the reset state
            phase_next = pwfp_pkg::PH_KEY;
            acc_next   = '0;
            cnt_next   = '0;
            rem_next   = '0;
            bpos_next  = '0;
            err_next   = pwfp_pkg::ERR_NONE;
        end

        if (res.kind == pwfp_pkg::KIND_END) begin
            res.field_number = '0;
            res.wire_type    = '0;
        end else begin
            res.field_number = fn_next;
            res.wire_type    = wt_next;
        end
        if (head.last) begin
            fn_next = '0;
            wt_next = '0;
        end

        produce = emit || head.last;

        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = produce;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= pwfp_pkg::PH_KEY;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            fn_reg        <= '0;
            wt_reg        <= '0;
            rem_reg       <= '0;
            bpos_reg      <= '0;
            err_reg       <= pwfp_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                fn_reg    <= fn_next;
                wt_reg    <= wt_next;
                rem_reg   <= rem_next;
                bpos_reg  <= bpos_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && produce) begin
            out_reg <= res;
        end
    end

endmodule

### rtl/protobuf_wire_field_parser_top.sv
// Top level of the protobuf wire-format field parser: input stage, queue,
// parser. Depends on pwfp_pkg, pwfp_front, pwfp_queue, pwfp_back.
//
//  channel  | dir | tdata                          | tuser     | tlast
//  ---------+-----+--------------------------------+-----------+---------------
//  s_ bytes | in  | data_byte                      | byte_valid| last
//  m_ fields| out | field/wire/value/pos/error     | kind      | end_of_message
//
// One byte per cycle sustained while m_tready keeps up; with an empty queue a
// byte passes the input hold register, the queue write and the output register.
// The parser state machine handles one queued byte per cycle while its output
// is taken; the four-entry queue lets input and output stall independently.
// aresetn is synchronous; it empties the queue and returns to key parsing.
// A bare marker without tlast is taken and dropped.
module protobuf_wire_field_parser_top #(
    parameter logic [63:0] MAX_MESSAGE_BYTES = pwfp_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pwfp_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] data_byte
    input  logic [0:0]                      s_tuser,  // [0] byte_valid
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] field_number, [34:32] wire_type, [98:35] value,
    // [114:99] position, [117:115] error_code, [119:118] zero
    output logic [pwfp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [2:0]                      m_tuser,  // [2:0] kind
    output logic                            m_tlast
);

    pwfp_pkg::qstat_t  qstat;
    pwfp_pkg::item_t   push_item;
    pwfp_pkg::item_t   head;
    pwfp_pkg::result_t result;
    logic              push;
    logic              pop;

    pwfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    pwfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    pwfp_back #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    assign m_tdata = {2'b00, result.error_code, result.position, result.value,
                      result.wire_type, result.field_number};
    assign m_tuser = result.kind;
    assign m_tlast = result.end_of_message;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qstat.count <= (pwfp_pkg::QUEUE_AW+1)'(pwfp_pkg::QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_error_only_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[117:115] == pwfp_pkg::ERR_NONE)
        else $error("error code on a result that does not close the message");

    a_end_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == pwfp_pkg::KIND_END |-> m_tlast)
        else $error("end-only result without end of message");

    a_end_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == pwfp_pkg::KIND_END |->
            m_tdata[98:0] == 99'd0)
        else $error("end-only result carries field data");
`endif

endmodule

### bench/protobuf_wire_field_parser_top_tb.sv
// Self-checking bench for protobuf_wire_field_parser_top: streams byte messages,
// predicts every field record in a small scoreboard and checks them in order.
// Depends on pwfp_pkg and the rtl of the parser top level.
module protobuf_wire_field_parser_top_tb;

    localparam int unsigned CYCLE_LIMIT   = 4_000_000;
    localparam int unsigned RANDOM_BYTES  = 1350;
    localparam int unsigned SETTLE_CYCLES = 16;

    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_RSVD6  = 3'd6;
    localparam logic [2:0] WT_RSVD7  = 3'd7;

    localparam logic [1:0] RX_ALWAYS  = 2'd0;
    localparam logic [1:0] RX_COIN    = 2'd1;
    localparam logic [1:0] RX_MOSTLY  = 2'd2;
    localparam logic [1:0] RX_PATTERN = 2'd3;

    typedef enum logic [1:0] {VI_MORE, VI_DONE, VI_LONG} varint_step_t;

    class field_scoreboard;
        pwfp_pkg::phase_t   ph;
        logic [63:0]        acc;
        int unsigned        vcnt;
        logic [31:0]        fnum;
        logic [2:0]         wt;
        logic [16:0]        remaining;
        logic [15:0]        bpos;
        pwfp_pkg::err_t     err_latched;
        pwfp_pkg::result_t  expected_q[$];
        int unsigned        mismatches;
        int unsigned        records_checked;
        int unsigned        messages;
        int unsigned        error_closes;

        function new();
            mismatches = 0;
            records_checked = 0;
            messages = 0;
            error_closes = 0;
            restart();
        endfunction

        function void restart();
            ph = pwfp_pkg::PH_KEY;
            acc = '0;
            vcnt = 0;
            fnum = '0;
            wt = '0;
            remaining = '0;
            bpos = '0;
            err_latched = pwfp_pkg::ERR_NONE;
        endfunction

        function void fail_with(pwfp_pkg::err_t code);
            err_latched = code;
            ph = pwfp_pkg::PH_DRAIN;
            acc = '0;
            vcnt = 0;
        endfunction

        function varint_step_t feed(logic [7:0] d);
            if (vcnt >= pwfp_pkg::VARINT_MAX_BYTES)
                return VI_LONG;
            acc = acc | ({57'd0, d[6:0]} << (7 * vcnt));
            vcnt++;
            return d[7] ? VI_MORE : VI_DONE;
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        // one accepted input transfer
        function void note_input(logic [7:0] d, logic v, logic l);
            pwfp_pkg::result_t r;
            bit                emit;
            logic [15:0]       here;
            logic [63:0]       key;
            varint_step_t      st;

            emit = 1'b0;
            here = '0;
            r.kind = pwfp_pkg::KIND_END;
            r.value = '0;
            r.position = '0;
            if (v) begin
                here = bpos;
                bpos = bpos + 16'd1;
                case (ph)
                    pwfp_pkg::PH_KEY: begin
                        st = feed(d);
                        if (st == VI_LONG) begin
                            fail_with(pwfp_pkg::ERR_LONG);
                        end else if (st == VI_DONE) begin
                            key = acc;
                            acc = '0;
                            vcnt = 0;
                            fnum = key[34:3];
                            wt = key[2:0];
                            if (fnum == '0) begin
                                fail_with(pwfp_pkg::ERR_FIELD0);
                            end else begin
                                case (wt)
                                    pwfp_pkg::WT_VARINT: ph = pwfp_pkg::PH_VALUE;
                                    pwfp_pkg::WT_LEN:    ph = pwfp_pkg::PH_LENGTH;
                                    pwfp_pkg::WT_I32: begin
                                        remaining = 17'(pwfp_pkg::FIXED32_BYTES);
                                        ph = pwfp_pkg::PH_SKIP;
                                    end
                                    pwfp_pkg::WT_I64: begin
                                        remaining = 17'(pwfp_pkg::FIXED64_BYTES);
                                        ph = pwfp_pkg::PH_SKIP;
                                    end
                                    default: fail_with(pwfp_pkg::ERR_WIRE);
                                endcase
                            end
                        end
                    end
                    pwfp_pkg::PH_VALUE: begin
                        st = feed(d);
                        if (st == VI_LONG) begin
                            fail_with(pwfp_pkg::ERR_LONG);
                        end else if (st == VI_DONE) begin
                            emit = 1'b1;
                            r.kind = pwfp_pkg::KIND_VARINT;
                            r.value = acc;
                            r.position = here;
                            acc = '0;
                            vcnt = 0;
                            ph = pwfp_pkg::PH_KEY;
                        end
                    end
                    pwfp_pkg::PH_LENGTH: begin
                        st = feed(d);
                        if (st == VI_LONG) begin
                            fail_with(pwfp_pkg::ERR_LONG);
                        end else if (st == VI_DONE) begin
                            key = acc;
                            acc = '0;
                            vcnt = 0;
                            if (key > pwfp_pkg::MAX_MESSAGE_BYTES_DEF) begin
                                fail_with(pwfp_pkg::ERR_LEN);
                            end else begin
                                emit = 1'b1;
                                r.kind = pwfp_pkg::KIND_LEN_HDR;
                                r.value = key;
                                r.position = bpos;
                                remaining = key[16:0];
                                ph = (key != '0) ? pwfp_pkg::PH_PAYLOAD : pwfp_pkg::PH_KEY;
                            end
                        end
                    end
                    pwfp_pkg::PH_PAYLOAD: begin
                        emit = 1'b1;
                        r.kind = pwfp_pkg::KIND_PAYLOAD;
                        r.value = {56'd0, d};
                        r.position = here;
                        if (remaining != '0)
                            remaining--;
                        if (remaining == '0)
                            ph = pwfp_pkg::PH_KEY;
                    end
                    pwfp_pkg::PH_SKIP: begin
                        if (remaining != '0)
                            remaining--;
                        if (remaining == '0) begin
                            emit = 1'b1;
                            r.kind = pwfp_pkg::KIND_FIXED;
                            r.position = here;
                            ph = pwfp_pkg::PH_KEY;
                        end
                    end
                    default: ;
                endcase
            end

            if (!emit && !l)
                return;

            r.error_code = pwfp_pkg::ERR_NONE;
            if (l) begin
                if (err_latched == pwfp_pkg::ERR_NONE &&
                    !(ph == pwfp_pkg::PH_KEY && vcnt == 0))
                    err_latched = pwfp_pkg::ERR_TRUNCATED;
                r.error_code = err_latched;
                if (!emit) begin
                    r.kind = pwfp_pkg::KIND_END;
                    r.value = '0;
                    r.position = bpos;
                end
                messages++;
                if (err_latched != pwfp_pkg::ERR_NONE)
                    error_closes++;
            end
            r.field_number = (r.kind == pwfp_pkg::KIND_END) ? '0 : fnum;
            r.wire_type = (r.kind == pwfp_pkg::KIND_END) ? '0 : wt;
            r.end_of_message = l;
            expected_q = {expected_q, r};
            if (l)
                restart();
        endfunction

        task compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
                report($sformatf("record %0d: %s expected %0h got %0h",
                                 records_checked, name, want, got));
        endtask

        task check_result(pwfp_pkg::result_t got, logic [1:0] pad);
            pwfp_pkg::result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("record kind %0d at position %0d with none expected",
                                 got.kind, got.position));
                return;
            end
            want = expected_q.pop_front();
            records_checked++;
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("field_number", 64'(want.field_number), 64'(got.field_number));
            compare_field("wire_type", 64'(want.wire_type), 64'(got.wire_type));
            compare_field("value", want.value, got.value);
            compare_field("position", 64'(want.position), 64'(got.position));
            compare_field("end_of_message", 64'(want.end_of_message),
                          64'(got.end_of_message));
            compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
            compare_field("tdata padding", '0, 64'(pad));
        endtask
    endclass

    logic                              aclk;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [pwfp_pkg::S_TDATA_W-1:0]    s_tdata  = '0;
    logic [0:0]                        s_tuser  = '0;
    logic                              s_tlast  = 1'b0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [pwfp_pkg::M_TDATA_W-1:0]    m_tdata;
    logic [2:0]                        m_tuser;
    logic                              m_tlast;

    field_scoreboard sb = new();

    int unsigned cycles         = 0;
    int          burst_left     = 0;
    int unsigned byte_transfers = 0;
    bit          hold_request   = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned mode_left      = 0;
    logic [1:0]  rx_mode        = RX_ALWAYS;
    logic [7:0]  stall_pattern  = 8'b1011_0110;
    logic [7:0]  msg_bytes[$];

    protobuf_wire_field_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d records still expected",
                     cycles, sb.outstanding());
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check each transfer, then choose the next ready value
    always @(posedge aclk) begin
        pwfp_pkg::result_t got;
        if (m_tvalid && m_tready) begin
            got.kind = pwfp_pkg::kind_t'(m_tuser);
            got.field_number = m_tdata[31:0];
            got.wire_type = m_tdata[34:32];
            got.value = m_tdata[98:35];
            got.position = m_tdata[114:99];
            got.error_code = pwfp_pkg::err_t'(m_tdata[117:115]);
            got.end_of_message = m_tlast;
            sb.check_result(got, m_tdata[119:118]);
        end
        if (mode_left == 0) begin
            rx_mode = 2'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 200);
        end else begin
            mode_left--;
        end
        if (hold_request) begin
            hold_left = $urandom_range(150, 300);
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                default: begin
                    m_tready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                end
            endcase
        end
    end

    task automatic push_item(input logic [7:0] d, input logic v, input logic l);
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 250)
                                                      : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= v;
        s_tlast <= l;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(d, v, l);
        burst_left--;
        if (v)
            byte_transfers++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() != 0);
    endtask

    task automatic send_message(input bit bare_end);
        foreach (msg_bytes[i]) begin
            if ($urandom_range(0, 31) == 0)
                push_item(8'($urandom), 1'b0, 1'b0);
            push_item(msg_bytes[i], 1'b1, !bare_end && i == msg_bytes.size() - 1);
        end
        if (bare_end || msg_bytes.size() == 0)
            push_item(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int unsigned varint_groups(logic [63:0] v);
        int unsigned n;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != '0)
            n++;
        return n;
    endfunction

    // n groups, continuation on all but the last; junk fills bits the tenth byte drops
    function automatic void put_varint(logic [63:0] v, int unsigned n, bit junk_top);
        logic [63:0] sh;
        logic [7:0]  b;
        for (int unsigned i = 0; i < n; i++) begin
            sh = v >> (7 * i);
            b = {(i != n - 1), sh[6:0]};
            if (i == 9 && junk_top)
                b[6:1] = 6'($urandom);
            msg_bytes = {msg_bytes, b};
        end
    endfunction

    function automatic void put_varint_padded(logic [63:0] v);
        int unsigned n;
        n = varint_groups(v);
        if ($urandom_range(0, 3) == 0)
            n += $urandom_range(0, 10 - n);
        put_varint(v, n, n == 10 && $urandom_range(0, 1) == 1);
    endfunction

    function automatic logic [63:0] rand_bits();
        int unsigned w;
        logic [63:0] r;
        w = $urandom_range(1, 64);
        r = {$urandom, $urandom};
        if (w < 64)
            r = r & ((64'd1 << w) - 64'd1);
        return r;
    endfunction

    function automatic logic [31:0] rand_field();
        logic [31:0] f;
        case ($urandom_range(0, 3))
            0: f = $urandom_range(1, 15);
            1: f = $urandom_range(16, 4095);
            2: f = $urandom;
            default: f = 32'hFFFF_FFFF;
        endcase
        if (f == '0)
            f = 32'd1;
        return f;
    endfunction

    // key bits above the field number are dropped by the parser
    function automatic void put_key(logic [31:0] f, logic [2:0] w);
        logic [63:0] key;
        key = {29'd0, f, w};
        if ($urandom_range(0, 9) == 0)
            key = key | (rand_bits() << 35);
        put_varint_padded(key);
    endfunction

    function automatic void add_good_field();
        int unsigned len;
        case ($urandom_range(0, 3))
            0: begin
                put_key(rand_field(), pwfp_pkg::WT_VARINT);
                put_varint_padded(rand_bits());
            end
            1: begin
                put_key(rand_field(), pwfp_pkg::WT_LEN);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                   : $urandom_range(0, 6);
                put_varint_padded(64'(len));
                repeat (len) msg_bytes = {msg_bytes, 8'($urandom)};
            end
            2: begin
                put_key(rand_field(), pwfp_pkg::WT_I32);
                repeat (pwfp_pkg::FIXED32_BYTES) msg_bytes = {msg_bytes, 8'($urandom)};
            end
            default: begin
                put_key(rand_field(), pwfp_pkg::WT_I64);
                repeat (pwfp_pkg::FIXED64_BYTES) msg_bytes = {msg_bytes, 8'($urandom)};
            end
        endcase
    endfunction

    function automatic void add_broken_field();
        logic [63:0] key;
        case ($urandom_range(0, 3))
            0: begin
                // eleven-byte varint as key, value or length
                case ($urandom_range(0, 2))
                    0: ;
                    1: put_key(rand_field(), pwfp_pkg::WT_VARINT);
                    default: put_key(rand_field(), pwfp_pkg::WT_LEN);
                endcase
                repeat (10) msg_bytes = {msg_bytes, 8'($urandom) | 8'h80};
                msg_bytes = {msg_bytes, 8'($urandom)};
            end
            1: begin
                key = {61'd0, 3'($urandom)};
                if ($urandom_range(0, 1) == 1)
                    key = key | (rand_bits() << 35);
                put_varint_padded(key);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: put_key(rand_field(), WT_SGROUP);
                    1: put_key(rand_field(), WT_EGROUP);
                    2: put_key(rand_field(), WT_RSVD6);
                    default: put_key(rand_field(), WT_RSVD7);
                endcase
            end
            default: begin
                put_key(rand_field(), pwfp_pkg::WT_LEN);
                if ($urandom_range(0, 1) == 1)
                    put_varint_padded(pwfp_pkg::MAX_MESSAGE_BYTES_DEF + 64'd1 +
                                      64'($urandom_range(0, 1000)));
                else
                    put_varint_padded({$urandom, $urandom} | 64'h2_0000);
            end
        endcase
        repeat ($urandom_range(0, 4)) msg_bytes = {msg_bytes, 8'($urandom)};
    endfunction

    initial begin
        int unsigned random_start;
        int unsigned msg_count;
        int unsigned pick;
        int unsigned cut;
        logic [31:0] big_field;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bare end marker straight after reset
        msg_bytes.delete();
        send_message(1'b1);
        // field 1, ten-byte all-ones value with junk in the tenth byte
        msg_bytes.delete();
        put_varint({29'd0, 32'd1, pwfp_pkg::WT_VARINT}, 1, 1'b0);
        put_varint('1, 10, 1'b1);
        send_message(1'b0);
        // zero-length field closes the message on its header
        msg_bytes.delete();
        put_varint({29'd0, 32'd2, pwfp_pkg::WT_LEN}, 1, 1'b0);
        put_varint('0, 1, 1'b0);
        send_message(1'b0);
        // field number zero
        msg_bytes.delete();
        put_varint({29'd0, 32'd0, pwfp_pkg::WT_I32}, 1, 1'b0);
        send_message(1'b0);
        // group wire type
        msg_bytes.delete();
        put_varint({29'd0, 32'd1, WT_SGROUP}, 1, 1'b0);
        msg_bytes = {msg_bytes, 8'hFF};
        send_message(1'b0);
        // length one above the limit
        msg_bytes.delete();
        put_varint({29'd0, 32'd3, pwfp_pkg::WT_LEN}, 1, 1'b0);
        put_varint(pwfp_pkg::MAX_MESSAGE_BYTES_DEF + 64'd1, 3, 1'b0);
        send_message(1'b1);
        // fixed64 cut short
        msg_bytes.delete();
        put_varint({29'd0, 32'd1, pwfp_pkg::WT_I64}, 1, 1'b0);
        msg_bytes = {msg_bytes, 8'h00};
        msg_bytes = {msg_bytes, 8'hFF};
        send_message(1'b0);

        random_start = byte_transfers;
        msg_count = 0;
        while (byte_transfers - random_start < RANDOM_BYTES) begin
            msg_bytes.delete();
            pick = $urandom_range(0, 99);
            repeat ($urandom_range(0, 5)) add_good_field();
            if (pick >= 70 && pick < 85) begin
                if (msg_bytes.size() == 0)
                    add_good_field();
                if (msg_bytes.size() > 1) begin
                    cut = $urandom_range(1, msg_bytes.size() - 1);
                    msg_bytes = msg_bytes[0:cut - 1];
                end
            end else if (pick >= 85) begin
                add_broken_field();
            end
            send_message($urandom_range(0, 3) == 0);
            msg_count++;
            if (msg_count % 25 == 7)
                hold_request = 1'b1;
            if (msg_count % 40 == 20)
                wait_for_drain();
        end

        // largest allowed length, cut off after a few payload bytes
        msg_bytes.delete();
        big_field = rand_field();
        put_key(big_field, pwfp_pkg::WT_LEN);
        put_varint(pwfp_pkg::MAX_MESSAGE_BYTES_DEF, 3, 1'b0);
        repeat ($urandom_range(1, 8)) msg_bytes = {msg_bytes, 8'($urandom)};
        send_message(1'b0);

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d byte transfers in %0d messages; %0d records checked,",
                 byte_transfers, sb.messages, sb.records_checked);
        $display("%0d messages closed on an error, one cut off at the largest length.",
                 sb.error_closes);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
